>>> hdl/ring_buffer_moving_average_unit_assert.svh
// ----------------------------------------------------------------------------
// Ring buffer moving average - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define RING_BUFFER_MOVING_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication
`define RBMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rbma_pkg.sv
// ----------------------------------------------------------------------------
// Ring buffer moving average - package
// Widths, register indexes, controller states and window length helper.
// ----------------------------------------------------------------------------
package rbma_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W       = 7;
    localparam int SUM_W       = 22;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE    = 2'd1;

    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = 7'd9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // zero acts as one, anything past the ring size acts as the ring size
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] wl);
        logic [LEN_W-1:0] res;
        if (wl == '0) begin
            res = LEN_W'(1);
        end else if (wl > LEN_W'(MAX_WINDOW)) begin
            res = LEN_W'(MAX_WINDOW);
        end else begin
            res = wl;
        end
        return res;
    endfunction

endpackage

>>> hdl/rbma_ram.sv
// ----------------------------------------------------------------------------
// Ring buffer moving average - sample RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbma_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rbma_div.sv
// ----------------------------------------------------------------------------
// Ring buffer moving average - divider
// Restoring bit-serial signed divide of the window sum by the window length,
// one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module rbma_div
    import rbma_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SUM_W-1:0]       i_dividend,
    input  logic [LEN_W-1:0]              i_divisor,
    output t_div_stat                     o_stat,
    output logic signed [SAMPLE_BITS-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_q;
    logic [LEN_W-1:0]     r_rem;
    logic [LEN_W-1:0]     r_div;

    logic [SUM_W-1:0]     w_mag;
    logic [LEN_W:0]       w_trial;
    logic                 w_fit;
    logic [SUM_W-1:0]     w_signed_q;

    assign w_mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // flag the cycle after the last quotient bit
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits LEN_W bits
            r_rem <= w_fit ? LEN_W'(w_trial - {1'b0, r_div}) : w_trial[LEN_W-1:0];
            r_q   <= {r_q[SUM_W-2:0], w_fit};
        end
    end

    assign w_signed_q = r_neg ? (~r_q + 1'b1) : r_q;

    assign o_quotient  = w_signed_q[SAMPLE_BITS-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> hdl/ring_buffer_moving_average_unit.sv
// ----------------------------------------------------------------------------
// Ring buffer moving average unit
// Boxcar average over the last window_length samples held in a RAM ring.
// ----------------------------------------------------------------------------
//  channel   valid         ready         payload
//  input     i_in_valid    o_in_ready    i_sample
//  output    o_out_valid   i_out_ready   o_average
//  config    i_cfg_valid   o_cfg_ready   i_cfg_index, i_cfg_data
//
//  From accept to result register: RAM read, closed by the ring and sum
//  update and divider start, then the divide, done and load.
//  Items are taken one at a time; the next item is accepted while a result
//  waits, and a full output register holds the load.
//  Synchronous active-low reset: window 9, fill 0, sum 0, position 0. Valid
//  bits mark written ring entries; reset or a length or fill write drops them.
// ----------------------------------------------------------------------------
`include "ring_buffer_moving_average_unit_assert.svh"

module ring_buffer_moving_average_unit
    import rbma_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    t_state                         r_state;
    t_state                         n_state;

    logic [LEN_W-1:0]               r_wl;
    logic signed [SAMPLE_BITS-1:0]  r_fill;
    logic signed [SUM_W-1:0]        r_sum;
    logic [ADDR_W-1:0]              r_pos;
    logic [MAX_WINDOW-1:0]          r_entry_valid;
    logic signed [SAMPLE_BITS-1:0]  r_sample;
    logic                           r_old_valid;
    logic signed [SAMPLE_BITS-1:0]  r_quot;
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_average;

    logic                           w_in_acc;
    logic                           w_cfg_acc;
    logic                           w_cfg_hit;
    logic                           w_ram_we;
    logic                           w_div_start;
    logic                           w_out_load;
    logic [LEN_W-1:0]               w_eff;
    logic [LEN_W-1:0]               n_wl;
    logic signed [SAMPLE_BITS-1:0]  n_fill;
    logic [LEN_W-1:0]               w_cfg_eff;
    logic signed [SAMPLE_BITS+LEN_W:0] w_cfg_prod;
    logic [SAMPLE_BITS-1:0]         w_rdata;
    logic signed [SAMPLE_BITS-1:0]  w_old;
    logic signed [SUM_W-1:0]        n_sum;
    logic [LEN_W-1:0]               w_pos_inc;
    t_div_stat                      w_div_stat;
    logic signed [SAMPLE_BITS-1:0]  w_div_quot;

    assign w_eff = eff_length(r_wl);

    // ---------------- controller ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        w_ram_we    = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_ready  = !i_cfg_valid;
                if (i_in_valid && !i_cfg_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_ram_we    = 1'b1;
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;
    assign w_cfg_hit = w_cfg_acc &&
                       ((i_cfg_index == REG_WINDOW_LENGTH) || (i_cfg_index == REG_FILL_VALUE));

    // ---------------- configuration ----------------
    always_comb begin
        n_wl   = r_wl;
        n_fill = r_fill;
        unique case (i_cfg_index)
            REG_WINDOW_LENGTH: n_wl   = i_cfg_data[LEN_W-1:0];
            REG_FILL_VALUE:    n_fill = i_cfg_data[SAMPLE_BITS-1:0];
            default: ;
        endcase
    end

    assign w_cfg_eff  = eff_length(n_wl);
    assign w_cfg_prod = n_fill * $signed({1'b0, w_cfg_eff});

    // ---------------- ring update ----------------
    rbma_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_sample),
        .i_re    (w_in_acc),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // an entry not written since the last clear holds the fill value
    assign w_old     = r_old_valid ? $signed(w_rdata) : r_fill;
    assign n_sum     = r_sum - SUM_W'(w_old) + SUM_W'(r_sample);
    assign w_pos_inc = LEN_W'(r_pos) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl          <= WINDOW_LENGTH_RESET;
            r_fill        <= '0;
            r_sum         <= '0;
            r_pos         <= '0;
            r_entry_valid <= '0;
        end else if (w_cfg_hit) begin
            r_wl          <= n_wl;
            r_fill        <= n_fill;
            r_sum         <= w_cfg_prod[SUM_W-1:0];
            r_pos         <= '0;
            r_entry_valid <= '0;
        end else if (w_ram_we) begin
            r_sum                <= n_sum;
            r_entry_valid[r_pos] <= 1'b1;
            r_pos                <= (w_pos_inc >= w_eff) ? '0 : w_pos_inc[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample    <= i_sample;
            r_old_valid <= r_entry_valid[r_pos];
        end
        if (w_div_stat.done) begin
            r_quot <= w_div_quot;
        end
    end

    // ---------------- divide ----------------
    rbma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (w_eff),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quot)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_average <= r_quot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;

    // ---------------- assertions ----------------
    `RBMA_ASSERT_NOW(a_pos_in_window, 1'b1, LEN_W'(r_pos) < w_eff,
        "write position outside window")
    `RBMA_ASSERT_NEXT(a_accept_reads, w_in_acc, r_state == S_READ,
        "accepted item did not move to ring read")
    `RBMA_ASSERT_NOW(a_div_done_state, w_div_stat.done, r_state == S_DIV,
        "divider finished outside divide state")
    `RBMA_ASSERT_NOW(a_div_idle_at_start, w_div_start, !w_div_stat.busy,
        "divider restarted while busy")
    `RBMA_ASSERT_NEXT(a_load_shows, w_out_load, r_out_valid && (r_state == S_IDLE),
        "result load did not present an item")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring buffer moving average unit - testbench
// Directed and random samples under several window lengths and fill values,
// random stalls on both sides; each average is checked against an in-bench
// boxcar predictor that tracks the ring, write position and running sum.
// ----------------------------------------------------------------------------
module testbench;
    import rbma_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1050;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [SAMPLE_BITS-1:0] o_average;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;

    ring_buffer_moving_average_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_average   (o_average),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // boxcar predictor state
    logic        [LEN_W-1:0]       reg_wlen;
    logic signed [SAMPLE_BITS-1:0] reg_fill;
    logic signed [SAMPLE_BITS-1:0] win_ring [MAX_WINDOW];
    int                            ring_pos;
    int                            ring_sum;

    logic signed [SAMPLE_BITS-1:0] expected_averages [$];

    int  error_count;
    int  cycle_count;
    int  items_sent;
    bit  in_held;
    bit  in_gaps;
    bit  out_stalls;
    int  rdy_left;
    bit  ready_next;
    int  rdy_pick;
    logic signed [SAMPLE_BITS-1:0] want_avg;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_len();
        if (reg_wlen == '0) begin
            return 1;
        end
        if (int'(reg_wlen) > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(reg_wlen);
    endfunction

    function automatic void clear_ring();
        for (int i = 0; i < MAX_WINDOW; i++) begin
            win_ring[i] = reg_fill;
        end
        ring_pos = 0;
        ring_sum = int'(reg_fill) * active_len();
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_LENGTH: begin
                reg_wlen = data[LEN_W-1:0];
                clear_ring();
            end
            REG_FILL_VALUE: begin
                reg_fill = data[SAMPLE_BITS-1:0];
                clear_ring();
            end
            default: begin
                // spare index: no write, no clear
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] predict_average(
            logic signed [SAMPLE_BITS-1:0] s);
        int n;
        int p;
        n = active_len();
        p = ring_pos;
        if (p >= n) begin
            p = 0;
        end
        ring_sum = ring_sum - int'(win_ring[p]) + int'(s);
        win_ring[p] = s;
        p++;
        if (p >= n) begin
            p = 0;
        end
        ring_pos = p;
        // int division truncates toward zero
        return SAMPLE_BITS'(ring_sum / n);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!in_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return SAMPLE_BITS'($urandom());
        end else if (r < 80) begin
            return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        end
        return SAMPLE_BITS'($urandom_range(0, 16) - 8);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_len_data();
        logic [CFG_DATA_W-1:0] data;
        int r;
        data = CFG_DATA_W'($urandom());
        r = $urandom_range(0, 99);
        if (r < 20) begin
            case ($urandom_range(0, 4))
                0: data[LEN_W-1:0] = 7'd0;
                1: data[LEN_W-1:0] = 7'd1;
                2: data[LEN_W-1:0] = 7'd64;
                3: data[LEN_W-1:0] = 7'd127;
                default: data[LEN_W-1:0] = LEN_W'($urandom_range(65, 126));
            endcase
        end else begin
            data[LEN_W-1:0] = LEN_W'($urandom_range(1, 64));
        end
        // keep the unused upper bits clear about half the time
        if ($urandom_range(0, 1) == 0) begin
            data[CFG_DATA_W-1:LEN_W] = '0;
        end
        return data;
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int gap;
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (!o_in_ready);
        expected_averages.push_back(predict_average(s));
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            in_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            in_held = 1'b1;
        end
    endtask

    task automatic end_stream();
        if (in_held) begin
            i_in_valid <= 1'b0;
            in_held = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        end_stream();
        while (expected_averages.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, data);
        i_cfg_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    task automatic test_power_up();
        // window 9, fill 0; small negatives truncate toward zero
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(-16'sd1);
        drain_results();
    endtask

    task automatic test_window_extremes();
        write_reg(REG_WINDOW_LENGTH, 16'd1);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        write_reg(REG_FILL_VALUE, 16'h7fff);
        write_reg(REG_WINDOW_LENGTH, 16'd64);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        write_reg(REG_FILL_VALUE, 16'h8000);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        // zero acts as one
        write_reg(REG_WINDOW_LENGTH, 16'd0);
        send_sample(16'sh1234);
        send_sample(-16'sd7);
        // upper data bits dropped, 127 saturates to the ring size
        write_reg(REG_WINDOW_LENGTH, 16'hffff);
        send_sample(16'sh7fff);
        send_sample(-16'sd3);
        write_reg(REG_WINDOW_LENGTH, 16'd65);
        send_sample(16'sh0100);
        drain_results();
    endtask

    task automatic test_spare_index();
        write_reg(REG_FILL_VALUE, 16'd100);
        write_reg(REG_WINDOW_LENGTH, 16'd3);
        send_sample(16'sd30);
        send_sample(-16'sd50);
        // spare indexes leave the ring as it is
        write_reg(REG_SPARE_2, 16'hffff);
        write_reg(REG_SPARE_3, 16'h5a5a);
        send_sample(16'sd7);
        send_sample(16'sd9);
        drain_results();
    endtask

    task automatic test_same_value_rewrite();
        write_reg(REG_WINDOW_LENGTH, 16'd3);
        send_sample(-16'sd11);
        drain_results();
    endtask

    task automatic test_back_to_back_pause();
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        write_reg(REG_WINDOW_LENGTH, 16'd5);
        for (int i = 0; i < 40; i++) begin
            send_sample(rand_sample());
        end
        // hold the sender until every average is back
        drain_results();
        for (int i = 0; i < 40; i++) begin
            send_sample(rand_sample());
        end
        drain_results();
    endtask

    task automatic test_random_phases();
        int target;
        int phase_items;
        int r;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
                write_reg(REG_WINDOW_LENGTH, rand_len_data());
            end else if (r < 5) begin
                write_reg(REG_FILL_VALUE, CFG_DATA_W'($urandom()));
            end else if (r < 8) begin
                write_reg(REG_FILL_VALUE, CFG_DATA_W'($urandom()));
                write_reg(REG_WINDOW_LENGTH, rand_len_data());
            end else if (r < 9) begin
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom()));
            end
            in_gaps     = ($urandom_range(0, 4) != 0);
            out_stalls  = ($urandom_range(0, 4) != 0);
            phase_items = $urandom_range(10, 120);
            for (int i = 0; i < phase_items; i++) begin
                send_sample(rand_sample());
            end
        end
        drain_results();
    endtask

    // check each accepted average and drive the receiver's stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_averages.size() == 0) begin
                $error("average: unexpected item, actual %0d", o_average);
                error_count++;
            end else begin
                want_avg = expected_averages.pop_front();
                if (o_average !== want_avg) begin
                    $error("average mismatch: expected %0d, actual %0d",
                           want_avg, o_average);
                    error_count++;
                end
            end
        end
        if (rdy_left == 0) begin
            if (!out_stalls) begin
                ready_next = 1'b1;
                rdy_left   = 8;
            end else begin
                rdy_pick = $urandom_range(0, 99);
                if (rdy_pick < 55) begin
                    ready_next = 1'b1;
                    rdy_left   = $urandom_range(1, 12);
                end else if (rdy_pick < 93) begin
                    ready_next = 1'b0;
                    rdy_left   = $urandom_range(1, 4);
                end else begin
                    ready_next = 1'b0;
                    rdy_left   = $urandom_range(20, 70);
                end
            end
            i_out_ready <= ready_next;
        end else begin
            rdy_left--;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        items_sent  = 0;
        in_held     = 1'b0;
        in_gaps     = 1'b1;
        out_stalls  = 1'b1;
        rdy_left    = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_WINDOW_LENGTH;
        i_cfg_data  <= '0;
        reg_wlen = WINDOW_LENGTH_RESET;
        reg_fill = '0;
        clear_ring();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up();
        test_window_extremes();
        test_spare_index();
        test_same_value_rewrite();
        test_back_to_back_pause();
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
        test_random_phases();

        drain_results();
        repeat (60) @(posedge i_clk);
        if (error_count == 0 && expected_averages.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
